@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent property checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property check with asynchronous active-low reset disable
`define CHECK_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("property check failed");

// property check that also holds during reset
`define CHECK_PROP_NR(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("property check failed");

`else

`define CHECK_PROP(label, clk, rst_n, prop)
`define CHECK_PROP_NR(label, clk, prop)

`endif

`endif

@@ hw/rtl/plip_pkg.sv @@
// ----------------------------------------------------------------------------
// plip_pkg
// shared types, constants and the escape table generator
// ----------------------------------------------------------------------------
package plip_pkg;

	localparam int unsigned DATA_W   = 16;  // Q8.8 registers and covariate
	localparam int unsigned PROB_W   = 17;  // Q0.16 with room for 1.0
	localparam int unsigned FACT_W   = 16;  // table entries, always below 1.0
	localparam int unsigned LOGIT_W  = 26;  // wide logit, no wrap
	localparam int unsigned SPAN_W   = 12;  // table spans 4096 logit codes
	localparam int unsigned CFG_IDX_W = 2;

	typedef logic signed [LOGIT_W-1:0] logit_t;
	typedef logic signed [DATA_W-1:0]  q88_t;
	typedef logic [PROB_W-1:0]         prob_t;

	localparam prob_t  ONE_Q16  = 17'h10000;
	localparam logit_t LOGIT_LO = -26'sd2048;
	localparam logit_t LOGIT_HI = 26'sd2048;

	localparam q88_t INTERCEPT_RST = -16'sd768;  // -3.0

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTERCEPT,
		REG_CAVE_GAIN,
		REG_PRE_EFFECT,
		REG_ACT_EFFECT
	} cfg_reg_t;

	// per-pair control carried down the pipeline
	typedef struct packed {
		logic  first;
		logic  present;
		logic  last;
		prob_t prior;
	} pair_ctl_t;

	localparam logic [63:0] ONE_Q30 = 64'h4000_0000;

	// restoring division, elaboration use only
	function automatic logic [63:0] div_floor(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], a[i]};
			if (rem >= b) begin
				rem    = rem - b;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-u), u and result in Q1.30
	function automatic logic [63:0] exp_neg_q30(input logic [63:0] u);
		logic [63:0] r;
		logic [63:0] term;
		logic [63:0] sum;
		r    = u >> 4;
		term = ONE_Q30;
		sum  = ONE_Q30;
		for (int n = 1; n < 40; n++) begin
			if (term != 0) begin
				term = div_floor((term * r) >> 30, 64'(n));
				if ((n % 2) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
		end
		for (int k = 0; k < 4; k++) begin
			sum = (sum * sum) >> 30;
		end
		return sum;
	endfunction

	// escape factor 1/(1+exp(c)) at the center of bin idx, Q0.16
	function automatic logic [FACT_W-1:0] esc_entry(input int unsigned idx,
			input int unsigned ents);
		logic [63:0] odd;
		logic [63:0] n64;
		logic [63:0] m;
		logic [63:0] u;
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] q;
		logic        neg;
		n64 = 64'(ents);
		odd = 64'(idx) * 2 + 1;
		neg = odd < n64;
		m   = neg ? n64 - odd : odd - n64;
		u   = div_floor((m << 34) + n64, 2 * n64);
		e   = exp_neg_q30(u);
		den = ONE_Q30 + e;
		num = neg ? ONE_Q30 : e;
		q   = div_floor(num * 2 * 64'h1_0000 + den, 2 * den);
		return q[FACT_W-1:0];
	endfunction

endpackage

@@ hw/rtl/plip_pair_if.sv @@
// ----------------------------------------------------------------------------
// plip_pair_if
// input channel: one (target, source) pair per transfer
// ----------------------------------------------------------------------------
interface plip_pair_if;

	logic                                    valid;
	logic                                    ready;
	logic                                    first_source;
	logic [plip_pkg::PROB_W-1:0]             prior_escape;
	logic signed [plip_pkg::DATA_W-1:0]      cave_covariate;
	logic                                    pre_treated;
	logic                                    act_treated;
	logic                                    source_present;
	logic                                    last_source;

	modport source (
		output valid, first_source, prior_escape, cave_covariate,
			pre_treated, act_treated, source_present, last_source,
		input  ready
	);

	modport sink (
		input  valid, first_source, prior_escape, cave_covariate,
			pre_treated, act_treated, source_present, last_source,
		output ready
	);

endinterface

@@ hw/rtl/plip_prob_if.sv @@
// ----------------------------------------------------------------------------
// plip_prob_if
// output channel: one infection probability per transfer
// ----------------------------------------------------------------------------
interface plip_prob_if;

	logic                        valid;
	logic                        ready;
	logic [plip_pkg::PROB_W-1:0] infection_prob;

	modport source (
		output valid, infection_prob,
		input  ready
	);

	modport sink (
		input  valid, infection_prob,
		output ready
	);

endinterface

@@ hw/rtl/plip_esc_rom.sv @@
// ----------------------------------------------------------------------------
// plip_esc_rom
// escape factor table, contents fixed at elaboration, registered read
// ----------------------------------------------------------------------------
module plip_esc_rom #(
	parameter int unsigned ENTRIES = 256,
	localparam int unsigned IDX_W  = $clog2(ENTRIES)
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [IDX_W-1:0]             addr,
	output logic [plip_pkg::FACT_W-1:0]  data
);

	logic [plip_pkg::FACT_W-1:0] rom [ENTRIES];

	for (genvar g = 0; g < ENTRIES; g++) begin : g_rom
		localparam logic [plip_pkg::FACT_W-1:0] ENTRY = plip_pkg::esc_entry(g, ENTRIES);
		assign rom[g] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data <= rom[addr];
		end
	end

endmodule

@@ hw/rtl/pairwise_logistic_infection_prob_unit.sv @@
// ----------------------------------------------------------------------------
// pairwise_logistic_infection_prob_unit
// Takes a stream of (target node, infected source) pairs and returns, on the
// last pair of each node, the probability that the node is infected, Q0.16.
// Each pair forms a Q8.8 logit from the intercept, the covariate gain times
// the target covariate, and the treatment effects; a table of SIGMOID_ENTRIES
// bins over [-8, 8) turns it into an escape factor, saturating at the ends.
// The running escape product is seeded by prior_escape on a node's first pair
// (clamped to 1.0) and multiplied with rounding by each present source's
// factor. Pairs stream at one transfer per clock: four pipeline stages
// (covariate multiply, logit sum, table index, table read) feed a registered
// product update, and the output register is loaded on a node's last pair.
// The only stall is a node's final pair reaching the update while the
// previous result has not been taken. Registers may be written only with no
// pair in flight; the table needs no fill time after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pairwise_logistic_infection_prob_unit #(
	parameter int unsigned SIGMOID_ENTRIES = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	plip_pair_if.sink                        pair,
	plip_prob_if.source                      prob,
	input  logic                             cfg_we,
	input  logic [plip_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [plip_pkg::DATA_W-1:0]      cfg_wdata
);

	localparam int unsigned IDX_W = $clog2(SIGMOID_ENTRIES);
	localparam int unsigned CNT_W = $clog2(SIGMOID_ENTRIES + 1);
	localparam int unsigned MUL_W = plip_pkg::SPAN_W + CNT_W;
	localparam int unsigned PRD_W = plip_pkg::PROB_W + plip_pkg::FACT_W;

	// configuration registers
	plip_pkg::q88_t intercept_q;
	plip_pkg::q88_t cave_gain_q;
	plip_pkg::q88_t pre_effect_q;
	plip_pkg::q88_t act_effect_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intercept_q  <= plip_pkg::INTERCEPT_RST;
			cave_gain_q  <= '0;
			pre_effect_q <= '0;
			act_effect_q <= '0;
		end else if (cfg_we) begin
			case (plip_pkg::cfg_reg_t'(cfg_idx))
				plip_pkg::REG_INTERCEPT:  intercept_q  <= cfg_wdata;
				plip_pkg::REG_CAVE_GAIN:  cave_gain_q  <= cfg_wdata;
				plip_pkg::REG_PRE_EFFECT: pre_effect_q <= cfg_wdata;
				plip_pkg::REG_ACT_EFFECT: act_effect_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline state
	logic                 v_s1, v_s2, v_s3, v_s4;
	plip_pkg::pair_ctl_t  ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic                 pre_s1, act_s1;
	logic signed [31:0]   prod_s1;
	plip_pkg::logit_t     logit_s2;
	logic [IDX_W-1:0]     idx_s3;
	logic [plip_pkg::FACT_W-1:0] factor_s4;

	plip_pkg::prob_t      escape_product_q;
	logic                 prob_valid_q;
	plip_pkg::prob_t      prob_data_q;

	logic                 advance;
	plip_pkg::prob_t      prior_clamped;
	plip_pkg::logit_t     logit_d;
	plip_pkg::logit_t     logit_off;
	logic [MUL_W-1:0]     idx_scaled;
	logic [IDX_W-1:0]     idx_d;
	plip_pkg::prob_t      seed;
	logic [PRD_W-1:0]     prod_rnd;
	plip_pkg::prob_t      escape_next;

	// everything moves together; hold only when a finished node meets a full output
	assign advance    = !(v_s4 && ctl_s4.last && prob_valid_q && !prob.ready);
	assign pair.ready = advance;

	// prior above 1.0 is taken as 1.0
	assign prior_clamped = (pair.prior_escape > plip_pkg::ONE_Q16)
		? plip_pkg::ONE_Q16 : pair.prior_escape;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= pair.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: covariate multiply, Q16.16
	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s1.first   <= pair.first_source;
			ctl_s1.present <= pair.source_present;
			ctl_s1.last    <= pair.last_source;
			ctl_s1.prior   <= prior_clamped;
			pre_s1         <= pair.pre_treated;
			act_s1         <= pair.act_treated;
			prod_s1        <= 32'(cave_gain_q) * 32'(pair.cave_covariate);
		end
	end

	// stage 2: logit sum, floor of the product back to Q8.8
	always_comb begin
		logit_d = plip_pkg::logit_t'(intercept_q)
			+ plip_pkg::logit_t'($signed(prod_s1[31:8]));
		if (pre_s1) begin
			logit_d = logit_d - plip_pkg::logit_t'(pre_effect_q);
		end
		if (act_s1) begin
			logit_d = logit_d - plip_pkg::logit_t'(act_effect_q);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s2   <= ctl_s1;
			logit_s2 <= logit_d;
		end
	end

	// stage 3: table index, saturating outside [-8, 8)
	assign logit_off  = logit_s2 + plip_pkg::LOGIT_HI;
	assign idx_scaled = MUL_W'(logit_off[plip_pkg::SPAN_W-1:0]) * MUL_W'(SIGMOID_ENTRIES);

	always_comb begin
		if (logit_s2 < plip_pkg::LOGIT_LO) begin
			idx_d = '0;
		end else if (logit_s2 >= plip_pkg::LOGIT_HI) begin
			idx_d = IDX_W'(SIGMOID_ENTRIES - 1);
		end else begin
			idx_d = idx_scaled[plip_pkg::SPAN_W +: IDX_W];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s3 <= ctl_s2;
			idx_s3 <= idx_d;
		end
	end

	// stage 4: table read
	plip_esc_rom #(
		.ENTRIES (SIGMOID_ENTRIES)
	) u_rom (
		.clk  (clk),
		.en   (advance),
		.addr (idx_s3),
		.data (factor_s4)
	);

	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s4 <= ctl_s3;
		end
	end

	// product update: seed, multiply with rounding, or pass when no source
	assign seed     = ctl_s4.first ? ctl_s4.prior : escape_product_q;
	assign prod_rnd = PRD_W'(seed) * PRD_W'(factor_s4) + PRD_W'(32768);
	assign escape_next = ctl_s4.present
		? prod_rnd[plip_pkg::FACT_W +: plip_pkg::PROB_W] : seed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_product_q <= plip_pkg::ONE_Q16;
		end else if (v_s4 && advance) begin
			escape_product_q <= escape_next;
		end
	end

	// result register, one transfer per finished node
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prob_valid_q <= 1'b0;
		end else if (v_s4 && ctl_s4.last && advance) begin
			prob_valid_q <= 1'b1;
		end else if (prob.ready) begin
			prob_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && ctl_s4.last && advance) begin
			prob_data_q <= plip_pkg::ONE_Q16 - escape_next;
		end
	end

	assign prob.valid          = prob_valid_q;
	assign prob.infection_prob = prob_data_q;

	// checks
	`CHECK_PROP(a_escape_le_one, clk, arst_n, escape_product_q <= plip_pkg::ONE_Q16)
	`CHECK_PROP(a_result_le_one, clk, arst_n, prob_valid_q |-> prob_data_q <= plip_pkg::ONE_Q16)
	`CHECK_PROP(a_result_from_last, clk, arst_n, $rose(prob_valid_q) |-> $past(v_s4 && ctl_s4.last))
	`CHECK_PROP(a_stall_holds_product, clk, arst_n, (v_s4 && ctl_s4.last && prob_valid_q && !prob.ready) |=> $stable(escape_product_q))

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pairwise_logistic_infection_prob_unit. A directed
// table covers the register and field extremes, prior clamping, table edges
// and node framing; random nodes then run under several register settings.
// Every pair transfer runs through a bench-side escape model. Each result
// transfer is compared in order with that model's value, or a hand-computed
// one where a directed row gives it. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

	localparam int LUT_N       = 256;     // table bins, also passed to the dut
	localparam int SETTLE      = 10;      // quiet cycles after the last result
	localparam int RAND_ITEMS  = 400;
	localparam int PHASES      = 8;
	localparam int CYCLE_LIMIT = 300000;

	// one pair as it goes over the input channel
	typedef struct {
		bit              first;
		plip_pkg::prob_t prior;
		plip_pkg::q88_t  cov;
		bit              pre;
		bit              act;
		bit              present;
		bit              last;
	} pair_item_t;

	// one row of the directed table: a register write or a pair
	typedef struct {
		bit                 is_write;
		plip_pkg::cfg_reg_t sel;
		int                 val;
		pair_item_t         pair;
		int                 typed;   // hand-computed result, -1 when predicted
	} dir_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [plip_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [plip_pkg::DATA_W-1:0]    cfg_wdata;

	plip_pair_if pair_ch ();
	plip_prob_if prob_ch ();

	pairwise_logistic_infection_prob_unit #(
		.SIGMOID_ENTRIES(LUT_N)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pair     (pair_ch),
		.prob     (prob_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// bench copy of the escape table and of the block's state
	logic [15:0]     esc_lut [LUT_N];
	plip_pkg::prob_t esc_prod;
	plip_pkg::q88_t  icpt_q;
	plip_pkg::q88_t  gain_q;
	plip_pkg::q88_t  pre_eff_q;
	plip_pkg::q88_t  act_eff_q;

	plip_pkg::prob_t pending_probs[$];   // infection probabilities still owed by the dut
	dir_row_t        dir_rows[$];
	int              error_count;
	int              cycle_count;
	bit              calm;               // no idling on either side while set
	int              stall_left;
	int              rx_roll;

	// ------------------------------------------------------------------------
	// clock and watchdog
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ends the run with an error if it runs past the cycle limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// escape model
	// ------------------------------------------------------------------------

	// exp(-u), Q1.30 in and out: series on u/16, then squared four times
	function automatic longint unsigned neg_exp_q30(input longint unsigned u);
		longint unsigned r;
		longint unsigned term;
		longint unsigned sum;
		r    = u >> 4;
		term = plip_pkg::ONE_Q30;
		sum  = plip_pkg::ONE_Q30;
		for (int n = 1; n < 40 && term != 0; n++) begin
			term = ((term * r) >> 30) / longint'(n);
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		for (int k = 0; k < 4; k++) begin
			sum = (sum * sum) >> 30;
		end
		return sum;
	endfunction

	// bin i holds 1/(1+exp(c)) at its center c, rounded to nearest in Q0.16
	function automatic void build_escape_lut();
		longint unsigned ents;
		longint unsigned odd;
		longint unsigned m;
		longint unsigned u;
		longint unsigned e;
		longint unsigned den;
		longint unsigned num;
		bit              below;
		ents = 64'(LUT_N);
		for (int i = 0; i < LUT_N; i++) begin
			odd   = 2 * longint'(i) + 1;
			below = odd < ents;
			m     = below ? ents - odd : odd - ents;
			u     = ((m << 34) + ents) / (2 * ents);
			e     = neg_exp_q30(u);
			den   = plip_pkg::ONE_Q30 + e;
			num   = below ? plip_pkg::ONE_Q30 : e;
			esc_lut[i] = 16'((num * 2 * 65536 + den) / (2 * den));
		end
	endfunction

	// advances the escape product by one pair; returns 1 when a result is due
	function automatic bit predict_pair(input pair_item_t it, output plip_pkg::prob_t want);
		longint          logit;
		int              idx;
		longint unsigned acc;
		if (it.first) begin
			esc_prod = (it.prior > plip_pkg::ONE_Q16) ? plip_pkg::ONE_Q16 : it.prior;
		end
		if (it.present) begin
			// floor of the Q16.16 product back to Q8.8, sum kept wide
			logit = longint'(gain_q) * longint'(it.cov);
			logit = (logit >>> 8) + longint'(icpt_q);
			if (it.pre) begin
				logit = logit - longint'(pre_eff_q);
			end
			if (it.act) begin
				logit = logit - longint'(act_eff_q);
			end
			// saturate outside [-8, 8)
			if (logit < -2048) begin
				idx = 0;
			end else if (logit >= 2048) begin
				idx = LUT_N - 1;
			end else begin
				idx = int'(((logit + 2048) * LUT_N) >>> 12);
			end
			acc      = (longint'(esc_prod) * longint'(esc_lut[idx]) + 32768) >> 16;
			esc_prod = plip_pkg::prob_t'(acc);
		end
		want = plip_pkg::ONE_Q16 - esc_prod;
		return it.last;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic int rand_range(input int lo, input int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (calm || roll < 60) begin
			return 0;
		end else if (roll < 90) begin
			return rand_range(1, 3);
		end
		return rand_range(8, 30);
	endfunction

	// seeds mostly in range, some exactly 1.0, some above it to hit the clamp
	function automatic plip_pkg::prob_t pick_prior();
		int roll;
		roll = $urandom_range(9);
		if (roll < 6) begin
			return plip_pkg::prob_t'($urandom_range(65536));
		end else if (roll < 8) begin
			return plip_pkg::ONE_Q16;
		end else if (roll == 8) begin
			return plip_pkg::prob_t'($urandom_range(131071));
		end
		return plip_pkg::prob_t'($urandom_range(255));
	endfunction

	function automatic void add_pair(input bit first, input int prior, input int cov,
			input bit pre, input bit act, input bit present, input bit last,
			input int typed);
		dir_row_t row;
		row.is_write     = 1'b0;
		row.sel          = plip_pkg::REG_INTERCEPT;
		row.val          = 0;
		row.pair.first   = first;
		row.pair.prior   = plip_pkg::prob_t'(prior);
		row.pair.cov     = plip_pkg::q88_t'(cov);
		row.pair.pre     = pre;
		row.pair.act     = act;
		row.pair.present = present;
		row.pair.last    = last;
		row.typed        = typed;
		dir_rows         = {dir_rows, row};
	endfunction

	function automatic void add_write(input plip_pkg::cfg_reg_t sel, input int val);
		dir_row_t row;
		row.is_write = 1'b1;
		row.sel      = sel;
		row.val      = val;
		row.pair     = '{default: 0};
		row.typed    = -1;
		dir_rows     = {dir_rows, row};
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		error_count++;
	endtask

	// register writes go in only with the block idle
	task automatic write_reg(input plip_pkg::cfg_reg_t sel, input int val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_idx   = sel;
		cfg_wdata = plip_pkg::DATA_W'(val);
		case (sel)
			plip_pkg::REG_INTERCEPT:  icpt_q    = plip_pkg::q88_t'(val);
			plip_pkg::REG_CAVE_GAIN:  gain_q    = plip_pkg::q88_t'(val);
			plip_pkg::REG_PRE_EFFECT: pre_eff_q = plip_pkg::q88_t'(val);
			plip_pkg::REG_ACT_EFFECT: act_eff_q = plip_pkg::q88_t'(val);
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// hold the sender until every owed result is back, then let the pipe empty
	task automatic drain_results();
		@(negedge clk);
		pair_ch.valid = 1'b0;
		while (pending_probs.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	// one pair transfer; valid stays up when the next pair follows at once
	task automatic push_pair(input pair_item_t it, input int typed);
		int              gap;
		plip_pkg::prob_t want;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			pair_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pair_ch.first_source   = it.first;
		pair_ch.prior_escape   = it.prior;
		pair_ch.cave_covariate = it.cov;
		pair_ch.pre_treated    = it.pre;
		pair_ch.act_treated    = it.act;
		pair_ch.source_present = it.present;
		pair_ch.last_source    = it.last;
		pair_ch.valid          = 1'b1;
		do begin
			@(posedge clk);
		end while (pair_ch.ready !== 1'b1);
		if (predict_pair(it, want)) begin
			pending_probs = {pending_probs,
				((typed >= 0) ? plip_pkg::prob_t'(typed) : want)};
		end
	endtask

	// ------------------------------------------------------------------------
	// result side: random stalls, in-order check of every result transfer
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left > 0) begin
			prob_ch.ready <= 1'b0;
			stall_left--;
		end else if (calm) begin
			prob_ch.ready <= 1'b1;
		end else begin
			rx_roll = $urandom_range(99);
			if (rx_roll < 70) begin
				prob_ch.ready <= 1'b1;
			end else if (rx_roll < 92) begin
				prob_ch.ready <= 1'b0;
				stall_left = $urandom_range(2);
			end else begin
				prob_ch.ready <= 1'b0;
				stall_left = rand_range(10, 40);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && prob_ch.valid === 1'b1 && prob_ch.ready === 1'b1) begin
			if (pending_probs.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing owed",
					prob_ch.infection_prob));
			end else if (prob_ch.infection_prob !== pending_probs[0]) begin
				report_mismatch($sformatf("infection_prob got %0d want %0d",
					prob_ch.infection_prob, pending_probs[0]));
				void'(pending_probs.pop_front());
			end else begin
				void'(pending_probs.pop_front());
			end
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		pair_item_t     it;
		plip_pkg::q88_t node_cov;
		bit             node_pre;
		int             node_len;
		int             sent;
		int             quota;

		// everything known from time zero, while reset is held
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_idx                = plip_pkg::REG_INTERCEPT;
		cfg_wdata              = '0;
		pair_ch.valid          = 1'b0;
		pair_ch.first_source   = 1'b0;
		pair_ch.prior_escape   = '0;
		pair_ch.cave_covariate = '0;
		pair_ch.pre_treated    = 1'b0;
		pair_ch.act_treated    = 1'b0;
		pair_ch.source_present = 1'b0;
		pair_ch.last_source    = 1'b0;
		prob_ch.ready          = 1'b0;
		error_count            = 0;
		stall_left             = 0;
		calm                   = 1'b0;
		icpt_q                 = plip_pkg::INTERCEPT_RST;
		gain_q                 = '0;
		pre_eff_q              = '0;
		act_eff_q              = '0;
		esc_prod               = plip_pkg::ONE_Q16;
		build_escape_lut();

		// reset values, no source: the result is one minus the clamped prior
		add_pair(1, 0, 0, 0, 0, 0, 1, 65536);
		add_pair(1, 65536, 0, 0, 0, 0, 1, 0);
		add_pair(1, 131071, 0, 0, 0, 0, 1, 0);       // prior above 1.0 clamps
		add_pair(1, 1, 0, 0, 0, 0, 1, 65535);
		// single-pair node under the reset intercept
		add_pair(1, 65536, 0, 0, 0, 1, 1, -1);
		// three-pair node, first two carry the covariate extremes
		add_pair(1, 40000, 32767, 1, 1, 1, 0, -1);
		add_pair(0, 0, -32768, 0, 0, 1, 0, -1);
		add_pair(0, 0, 0, 0, 0, 0, 1, -1);           // no source, just emits
		add_pair(0, 65536, 0, 0, 0, 1, 1, -1);       // no first after emit: old product
		// covariate gain at both extremes drives the logit far past the table
		add_write(plip_pkg::REG_CAVE_GAIN, 32767);
		add_write(plip_pkg::REG_INTERCEPT, 0);
		add_pair(1, 65536, 32767, 0, 0, 1, 1, -1);
		add_pair(1, 65536, -32768, 0, 0, 1, 1, -1);
		add_write(plip_pkg::REG_CAVE_GAIN, -32768);
		add_pair(1, 65536, -32768, 0, 0, 1, 1, -1);
		add_pair(1, 65536, 32767, 1, 1, 1, 1, -1);
		// treatment effects at the extremes, each flag alone and together
		add_write(plip_pkg::REG_CAVE_GAIN, 0);
		add_write(plip_pkg::REG_PRE_EFFECT, -32768);
		add_write(plip_pkg::REG_ACT_EFFECT, 32767);
		add_write(plip_pkg::REG_INTERCEPT, 32767);
		add_pair(1, 65536, 0, 1, 1, 1, 1, -1);
		add_pair(1, 65536, 0, 1, 0, 1, 1, -1);
		add_pair(1, 65536, 0, 0, 1, 1, 1, -1);
		add_write(plip_pkg::REG_INTERCEPT, -32768);
		add_pair(1, 65536, 0, 0, 1, 1, 1, -1);
		// logits right at the table edges
		add_write(plip_pkg::REG_ACT_EFFECT, 0);
		add_write(plip_pkg::REG_PRE_EFFECT, 0);
		add_write(plip_pkg::REG_INTERCEPT, -2049);
		add_pair(1, 65536, 0, 0, 0, 1, 1, -1);
		add_write(plip_pkg::REG_INTERCEPT, -2048);
		add_pair(1, 65536, 0, 0, 0, 1, 1, -1);
		add_write(plip_pkg::REG_INTERCEPT, 2047);
		add_pair(1, 65536, 0, 0, 0, 1, 1, -1);
		add_write(plip_pkg::REG_INTERCEPT, 2048);
		add_pair(1, 65536, 0, 0, 0, 1, 1, -1);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_write) begin
				drain_results();
				write_reg(dir_rows[i].sel, dir_rows[i].val);
			end else begin
				push_pair(dir_rows[i].pair, dir_rows[i].typed);
			end
		end

		// random phases, each under its own register setting
		quota = RAND_ITEMS / PHASES;
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			calm = (p % 4 == 3);
			if (p == 0) begin
				write_reg(plip_pkg::REG_INTERCEPT, 32767);
				write_reg(plip_pkg::REG_CAVE_GAIN, 32767);
				write_reg(plip_pkg::REG_PRE_EFFECT, 32767);
				write_reg(plip_pkg::REG_ACT_EFFECT, 32767);
			end else if (p == 1) begin
				write_reg(plip_pkg::REG_INTERCEPT, -32768);
				write_reg(plip_pkg::REG_CAVE_GAIN, -32768);
				write_reg(plip_pkg::REG_PRE_EFFECT, -32768);
				write_reg(plip_pkg::REG_ACT_EFFECT, -32768);
			end else if (p == 2) begin
				write_reg(plip_pkg::REG_INTERCEPT, -32768);
				write_reg(plip_pkg::REG_CAVE_GAIN, 32767);
				write_reg(plip_pkg::REG_PRE_EFFECT, 32767);
				write_reg(plip_pkg::REG_ACT_EFFECT, -32768);
			end else if (p % 3 == 0) begin
				// any 16-bit pattern
				write_reg(plip_pkg::REG_INTERCEPT, int'($urandom_range(65535)));
				write_reg(plip_pkg::REG_CAVE_GAIN, int'($urandom_range(65535)));
				write_reg(plip_pkg::REG_PRE_EFFECT, int'($urandom_range(65535)));
				write_reg(plip_pkg::REG_ACT_EFFECT, int'($urandom_range(65535)));
			end else begin
				// logits mostly land inside the table
				write_reg(plip_pkg::REG_INTERCEPT, rand_range(-2600, 2600));
				write_reg(plip_pkg::REG_CAVE_GAIN, rand_range(-768, 768));
				write_reg(plip_pkg::REG_PRE_EFFECT, rand_range(-1536, 1536));
				write_reg(plip_pkg::REG_ACT_EFFECT, rand_range(-1536, 1536));
			end

			sent = 0;
			while (sent < quota) begin
				if ($urandom_range(99) < 85) begin
					// well-framed node: first on the opening pair, last on the closing one
					node_len = ($urandom_range(9) == 0) ? rand_range(7, 12) : rand_range(1, 6);
					node_cov = ($urandom_range(1) == 1) ? plip_pkg::q88_t'($urandom)
						: plip_pkg::q88_t'(rand_range(-1024, 1024));
					node_pre = 1'($urandom_range(1));
					for (int k = 0; k < node_len; k++) begin
						it.first   = (k == 0);
						it.last    = (k == node_len - 1);
						it.prior   = pick_prior();
						it.cov     = node_cov;
						it.pre     = node_pre;
						it.act     = 1'($urandom_range(1));
						it.present = ($urandom_range(9) != 0);
						push_pair(it, -1);
						sent++;
					end
				end else begin
					// broken framing: any mix of first and last
					it.first   = 1'($urandom_range(1));
					it.last    = 1'($urandom_range(1));
					it.prior   = pick_prior();
					it.cov     = plip_pkg::q88_t'($urandom);
					it.pre     = 1'($urandom_range(1));
					it.act     = 1'($urandom_range(1));
					it.present = 1'($urandom_range(1));
					push_pair(it, -1);
					sent++;
				end
			end
		end

		// wind down: all results back, then a quiet settle period
		@(negedge clk);
		pair_ch.valid = 1'b0;
		calm          = 1'b0;
		while (pending_probs.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
